### sv/assert_macros.svh
// Assertion helpers for the shader RTL. Both macros sample on aclk and
// stay quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled clock edge.
`define TLPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// The expression must never be true at a sampled clock edge.
`define TLPS_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

### sv/tlps_pkg.sv
package tlps_pkg;

    // Default parameter values.
    localparam int COORD_WIDTH_DEF    = 16;
    localparam int SHININESS_LOG2_DEF = 5;

    // Field widths.
    localparam int FIELD_W   = 16;
    localparam int AMB_W     = 14;
    localparam int GAIN_W    = 16;
    localparam int GAINS_W   = 3 * GAIN_W;
    localparam int CHANNELS  = 3;
    localparam int FRAC_BITS = 14;
    localparam int UNIT_ONE  = 16384;

    // Configuration port.
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    typedef enum logic [2:0] {
        REG_LIGHT_ONE_X,
        REG_LIGHT_ONE_Y,
        REG_LIGHT_TWO_X,
        REG_LIGHT_TWO_Y,
        REG_VIEWER_X,
        REG_VIEWER_Y,
        REG_AMBIENT_LEVEL,
        REG_MATERIAL_GAINS
    } reg_index_t;

    localparam logic [FIELD_W-1:0] RST_LIGHT_ONE_X = 16'h2000;
    localparam logic [FIELD_W-1:0] RST_LIGHT_ONE_Y = 16'hC000;
    localparam logic [FIELD_W-1:0] RST_LIGHT_TWO_X = 16'h2000;
    localparam logic [FIELD_W-1:0] RST_LIGHT_TWO_Y = 16'h4000;
    localparam logic [FIELD_W-1:0] RST_VIEWER_X    = 16'h0000;
    localparam logic [FIELD_W-1:0] RST_VIEWER_Y    = 16'h0000;
    localparam logic [AMB_W-1:0]   RST_AMBIENT     = 14'd3277;
    localparam logic [GAINS_W-1:0] RST_GAINS       = 48'h4CCD_4000_6000;

    // Vector lanes of the normalizer.
    localparam int LANES          = 4;
    localparam int LANE_NORMAL    = 0;
    localparam int LANE_LIGHT_ONE = 1;
    localparam int LANE_VIEWER    = 3;

    // Internal widths.
    localparam int NV_W  = 64;  // squared length and root recurrence
    localparam int AW    = 33;  // scaled component magnitude
    localparam int M_W   = 32;  // square root
    localparam int Q_W   = 15;  // unit magnitude, at most 2^14
    localparam int U_W   = 16;  // signed unit component
    localparam int DOT_W = 40;
    localparam int NUM_W = AW + FRAC_BITS + 1;

    // Normalizer stage map.
    localparam int ST_SUM       = 1;
    localparam int ST_NRM0      = 2;
    localparam int NRM_STEPS    = 5;
    localparam int ST_SQRT0     = ST_NRM0 + NRM_STEPS;
    localparam int SQRT_STEPS   = M_W;
    localparam int ST_DIV_SETUP = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV0      = ST_DIV_SETUP + 1;
    localparam int DIV_STEPS    = Q_W;
    localparam int ST_SIGN      = ST_DIV0 + DIV_STEPS;
    localparam int NORM_STAGES  = ST_SIGN + 1;

    typedef struct packed {
        logic                  ok;
        logic                  neg_x;
        logic                  neg_y;
        logic [AW-1:0]         ax;
        logic [AW-1:0]         ay;
        logic [NV_W-1:0]       v;
        logic [NV_W-1:0]       root;
        logic [M_W-1:0]        m;
        logic [AW-1:0]         rx;
        logic [AW-1:0]         ry;
        logic [Q_W-1:0]        xlo;
        logic [Q_W-1:0]        ylo;
        logic [Q_W-1:0]        qx;
        logic [Q_W-1:0]        qy;
        logic signed [U_W-1:0] ux;
        logic signed [U_W-1:0] uy;
    } norm_t;

    // Rounds a Q.28 dot product to Q.14, clamped to [0, 1.0].
    function automatic logic [Q_W-1:0] clamp_dot(input logic signed [DOT_W-1:0] d);
        logic [DOT_W-1:0] r;
        logic [Q_W-1:0]   res;
        r = ($unsigned(d) + DOT_W'(8192)) >> FRAC_BITS;
        if (d <= 0) begin
            res = '0;
        end else if (r > DOT_W'(UNIT_ONE)) begin
            res = Q_W'(UNIT_ONE);
        end else begin
            res = Q_W'(r);
        end
        return res;
    endfunction

    // A normalizer stage: sum of squares, normalize by 16, 8, 4, 2, 1 bits,
    // one root bit per stage, one quotient bit per stage, then the sign.
    function automatic norm_t norm_step(input norm_t a, input int j);
        norm_t            r;
        logic [NV_W-1:0]  bit_v;
        logic [NV_W-1:0]  trial;
        logic [AW-1:0]    tx;
        logic [AW-1:0]    ty;
        logic [AW-1:0]    mm;
        logic [NUM_W-1:0] nx_full;
        logic [NUM_W-1:0] ny_full;
        int               k;
        int               b;
        r       = a;
        bit_v   = '0;
        trial   = '0;
        mm      = {1'b0, a.m};
        tx      = {a.rx[AW-2:0], a.xlo[Q_W-1]};
        ty      = {a.ry[AW-2:0], a.ylo[Q_W-1]};
        nx_full = '0;
        ny_full = '0;
        k       = 0;
        b       = 0;
        if (j == ST_SUM) begin
            r.v    = a.v + a.root;
            r.root = '0;
            r.ok   = (a.v + a.root) != '0;
        end else if (j >= ST_NRM0 && j < ST_SQRT0) begin
            k = 16 >> (j - ST_NRM0);
            if ((a.v >> (62 - 2 * k)) == '0) begin
                r.v  = a.v << (2 * k);
                r.ax = a.ax << k;
                r.ay = a.ay << k;
            end
        end else if (j >= ST_SQRT0 && j < ST_DIV_SETUP) begin
            b     = SQRT_STEPS - 1 - (j - ST_SQRT0);
            bit_v = NV_W'(1) << (2 * b);
            trial = a.root + bit_v;
            if (a.v >= trial) begin
                r.v    = a.v - trial;
                r.root = (a.root >> 1) + bit_v;
            end else begin
                r.root = a.root >> 1;
            end
        end else if (j == ST_DIV_SETUP) begin
            // Numerator is |c| * 2^(14+s) plus half the root, for rounding.
            r.m     = a.root[M_W-1:0];
            nx_full = {1'b0, a.ax, {FRAC_BITS{1'b0}}} + NUM_W'(a.root[M_W-1:1]);
            ny_full = {1'b0, a.ay, {FRAC_BITS{1'b0}}} + NUM_W'(a.root[M_W-1:1]);
            r.rx    = nx_full[NUM_W-1:Q_W];
            r.ry    = ny_full[NUM_W-1:Q_W];
            r.xlo   = nx_full[Q_W-1:0];
            r.ylo   = ny_full[Q_W-1:0];
            r.qx    = '0;
            r.qy    = '0;
        end else if (j >= ST_DIV0 && j < ST_SIGN) begin
            r.xlo = a.xlo << 1;
            r.ylo = a.ylo << 1;
            if (tx >= mm) begin
                r.rx = tx - mm;
                r.qx = {a.qx[Q_W-2:0], 1'b1};
            end else begin
                r.rx = tx;
                r.qx = {a.qx[Q_W-2:0], 1'b0};
            end
            if (ty >= mm) begin
                r.ry = ty - mm;
                r.qy = {a.qy[Q_W-2:0], 1'b1};
            end else begin
                r.ry = ty;
                r.qy = {a.qy[Q_W-2:0], 1'b0};
            end
        end else if (j == ST_SIGN) begin
            if (!a.ok) begin
                r.ux = '0;
                r.uy = '0;
            end else begin
                r.ux = a.neg_x ? -$signed({1'b0, a.qx}) : $signed({1'b0, a.qx});
                r.uy = a.neg_y ? -$signed({1'b0, a.qy}) : $signed({1'b0, a.qy});
            end
        end
        return r;
    endfunction

endpackage

### sv/two_light_phong_shader.sv
// Channel   | Ports          | Beat contents, lowest bits first
// ----------+----------------+------------------------------------------------
// sample in | s_axis_*       | tdata[31:0]: normal_x[15:0], normal_y[31:16]
// color out | m_axis_*       | tdata[47:0]: red, green, blue, 16 bits each
// registers | psel..prdata   | eight registers at byte address 8*index
//
// One beat is accepted every clock cycle while the output is not stalled.
// Most of the pipeline depth comes from the square root and the divider,
// which retire one bit per stage.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. A stall on the output freezes every stage at once, so
// nothing is dropped or repeated; the input is ready whenever the output
// register is empty or being taken.
`include "assert_macros.svh"

module two_light_phong_shader #(
    parameter int COORD_WIDTH    = tlps_pkg::COORD_WIDTH_DEF,
    parameter int SHININESS_LOG2 = tlps_pkg::SHININESS_LOG2_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Sample input beats.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [2*tlps_pkg::FIELD_W-1:0]        s_axis_tdata,  // normal_x, normal_y
    // Color output beats.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [3*tlps_pkg::FIELD_W-1:0]        m_axis_tdata,  // red, green, blue
    // Register port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tlps_pkg::PADDR_W-1:0]          paddr,
    input  logic [tlps_pkg::PDATA_W-1:0]          pwdata,
    output logic [tlps_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);
    import tlps_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int P     = SHININESS_LOG2;
    localparam int ST_A  = NORM_STAGES;      // dot product terms
    localparam int ST_B  = ST_A + 1;         // dot product sum
    localparam int ST_C  = ST_B + 1;         // diffuse clamp, d*n
    localparam int ST_D  = ST_C + 1;         // reflection vector
    localparam int ST_E  = ST_D + 1;         // R.V terms
    localparam int ST_F  = ST_E + 1;         // R.V sum
    localparam int ST_G  = ST_F + 1;         // specular clamp
    localparam int ST_T  = ST_G + P + 1;     // light term sum
    localparam int ST_M  = ST_T + 1;         // gain products
    localparam int TOTAL = ST_M + 2;         // last stage is the output register
    localparam logic signed [49:0] HALF_Q28 = 50'sd134217728;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] l1x_reg, l1x_next, l1y_reg, l1y_next;
    logic [FIELD_W-1:0] l2x_reg, l2x_next, l2y_reg, l2y_next;
    logic [FIELD_W-1:0] vwx_reg, vwx_next, vwy_reg, vwy_next;
    logic [AMB_W-1:0]   amb_reg, amb_next;
    logic [GAINS_W-1:0] gains_reg, gains_next;
    logic               apb_wr;
    reg_index_t         reg_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_index_t'(paddr[PADDR_W-1:3]);

    always_comb begin
        l1x_next   = l1x_reg;
        l1y_next   = l1y_reg;
        l2x_next   = l2x_reg;
        l2y_next   = l2y_reg;
        vwx_next   = vwx_reg;
        vwy_next   = vwy_reg;
        amb_next   = amb_reg;
        gains_next = gains_reg;
        if (apb_wr) begin
            unique case (reg_idx)
                REG_LIGHT_ONE_X:    l1x_next   = pwdata[FIELD_W-1:0];
                REG_LIGHT_ONE_Y:    l1y_next   = pwdata[FIELD_W-1:0];
                REG_LIGHT_TWO_X:    l2x_next   = pwdata[FIELD_W-1:0];
                REG_LIGHT_TWO_Y:    l2y_next   = pwdata[FIELD_W-1:0];
                REG_VIEWER_X:       vwx_next   = pwdata[FIELD_W-1:0];
                REG_VIEWER_Y:       vwy_next   = pwdata[FIELD_W-1:0];
                REG_AMBIENT_LEVEL:  amb_next   = pwdata[AMB_W-1:0];
                REG_MATERIAL_GAINS: gains_next = pwdata[GAINS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LIGHT_ONE_X:    prdata = PDATA_W'(l1x_reg);
            REG_LIGHT_ONE_Y:    prdata = PDATA_W'(l1y_reg);
            REG_LIGHT_TWO_X:    prdata = PDATA_W'(l2x_reg);
            REG_LIGHT_TWO_Y:    prdata = PDATA_W'(l2y_reg);
            REG_VIEWER_X:       prdata = PDATA_W'(vwx_reg);
            REG_VIEWER_Y:       prdata = PDATA_W'(vwy_reg);
            REG_AMBIENT_LEVEL:  prdata = PDATA_W'(amb_reg);
            REG_MATERIAL_GAINS: prdata = PDATA_W'(gains_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1x_reg   <= RST_LIGHT_ONE_X;
            l1y_reg   <= RST_LIGHT_ONE_Y;
            l2x_reg   <= RST_LIGHT_TWO_X;
            l2y_reg   <= RST_LIGHT_TWO_Y;
            vwx_reg   <= RST_VIEWER_X;
            vwy_reg   <= RST_VIEWER_Y;
            amb_reg   <= RST_AMBIENT;
            gains_reg <= RST_GAINS;
        end else begin
            l1x_reg   <= l1x_next;
            l1y_reg   <= l1y_next;
            l2x_reg   <= l2x_next;
            l2y_reg   <= l2y_next;
            vwx_reg   <= vwx_next;
            vwy_reg   <= vwy_next;
            amb_reg   <= amb_next;
            gains_reg <= gains_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together; valid bits ride along.
    // ------------------------------------------------------------------
    logic             adv;
    logic [TOTAL-1:0] valid_reg, valid_next;

    assign adv           = !valid_reg[TOTAL-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[TOTAL-1];
    assign valid_next    = {valid_reg[TOTAL-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Normalizer: four lanes (normal, two lights, viewer) share the same stages.
    // The user must change the register-fed lanes only while the pipeline is empty,
    // not enforced by the block; each beat then carries its settings' unit vectors.
    // ------------------------------------------------------------------
    function automatic norm_t norm_entry(input logic [W-1:0] x, input logic [W-1:0] y);
        norm_t          r;
        logic [W-1:0]   axv;
        logic [W-1:0]   ayv;
        logic [2*W-1:0] sx;
        logic [2*W-1:0] sy;
        r       = '0;
        axv     = x[W-1] ? (~x + 1'b1) : x;
        ayv     = y[W-1] ? (~y + 1'b1) : y;
        sx      = axv * axv;
        sy      = ayv * ayv;
        r.neg_x = x[W-1];
        r.neg_y = y[W-1];
        r.ax    = AW'(axv);
        r.ay    = AW'(ayv);
        r.v     = NV_W'(sx);
        r.root  = NV_W'(sy);
        return r;
    endfunction

    logic [W-1:0] raw_x [LANES];
    logic [W-1:0] raw_y [LANES];
    norm_t        norm_reg  [NORM_STAGES][LANES];
    norm_t        norm_next [NORM_STAGES][LANES];

    // Coordinates are read as W-bit two's complement.
    always_comb begin
        raw_x[0] = W'(s_axis_tdata[FIELD_W-1:0]);
        raw_y[0] = W'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
        raw_x[1] = W'(l1x_reg);
        raw_y[1] = W'(l1y_reg);
        raw_x[2] = W'(l2x_reg);
        raw_y[2] = W'(l2y_reg);
        raw_x[3] = W'(vwx_reg);
        raw_y[3] = W'(vwy_reg);
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            norm_next[0][l] = norm_entry(raw_x[l], raw_y[l]);
            for (int j = 1; j < NORM_STAGES; j++) begin
                norm_next[j][l] = norm_step(norm_reg[j-1][l], j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            norm_reg <= norm_next;
        end
    end

    // Unit vectors of the settings, captured as each beat leaves the
    // normalizer. Later stages read them; all beats in flight share them.
    logic signed [U_W-1:0] cur_lx_reg [2], cur_lx_next [2];
    logic signed [U_W-1:0] cur_ly_reg [2], cur_ly_next [2];
    logic [1:0]            cur_lok_reg, cur_lok_next;
    logic signed [U_W-1:0] cur_vx_reg, cur_vx_next, cur_vy_reg, cur_vy_next;
    logic                  cur_vok_reg, cur_vok_next;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cur_lx_next[l]  = norm_reg[NORM_STAGES-1][LANE_LIGHT_ONE+l].ux;
            cur_ly_next[l]  = norm_reg[NORM_STAGES-1][LANE_LIGHT_ONE+l].uy;
            cur_lok_next[l] = norm_reg[NORM_STAGES-1][LANE_LIGHT_ONE+l].ok;
        end
        cur_vx_next  = norm_reg[NORM_STAGES-1][LANE_VIEWER].ux;
        cur_vy_next  = norm_reg[NORM_STAGES-1][LANE_VIEWER].uy;
        cur_vok_next = norm_reg[NORM_STAGES-1][LANE_VIEWER].ok;
    end

    always_ff @(posedge aclk) begin
        if (adv && valid_reg[NORM_STAGES-1]) begin
            cur_lx_reg  <= cur_lx_next;
            cur_ly_reg  <= cur_ly_next;
            cur_lok_reg <= cur_lok_next;
            cur_vx_reg  <= cur_vx_next;
            cur_vy_reg  <= cur_vy_next;
            cur_vok_reg <= cur_vok_next;
        end
    end

    // ------------------------------------------------------------------
    // Shading stages, two lights side by side.
    // ------------------------------------------------------------------
    logic signed [31:0]       dpx_reg [2], dpx_next [2], dpy_reg [2], dpy_next [2];
    logic signed [31:0]       d_reg [2], d_next [2];
    logic signed [47:0]       tx_reg [2], tx_next [2], ty_reg [2], ty_next [2];
    logic [Q_W-1:0]           diffc_reg [2], diffc_next [2];
    logic [Q_W-1:0]           diffd_reg [2], diffd_next [2];
    logic [Q_W-1:0]           diffe_reg [2], diffe_next [2];
    logic [Q_W-1:0]           difff_reg [2], difff_next [2];
    logic signed [19:0]       px_reg [2], px_next [2], py_reg [2], py_next [2];
    logic signed [49:0]       shx [2], shy [2];
    logic signed [35:0]       ex_reg [2], ex_next [2], ey_reg [2], ey_next [2];
    logic signed [36:0]       sd_reg [2], sd_next [2];
    logic [Q_W-1:0]           sq_reg [P+1][2], sq_next [P+1][2];
    logic [Q_W-1:0]           dq_reg [P+1][2], dq_next [P+1][2];
    logic [P:0]               nokq_reg, nokq_next;
    logic [28:0]              sqp [P+1][2];
    logic signed [U_W-1:0]    nax_reg, nax_next, nay_reg, nay_next;
    logic signed [U_W-1:0]    nbx_reg, nbx_next, nby_reg, nby_next;
    logic                     noka_reg, nokb_reg, nokc_reg, nokd_reg, noke_reg, nokf_reg;
    logic [16:0]              tsum_reg, tsum_next;
    logic [16:0]              term [2];
    logic [32:0]              prod_reg [CHANNELS], prod_next [CHANNELS];
    logic [34:0]              acc [CHANNELS];
    logic [FIELD_W-1:0]       out_reg [CHANNELS], out_next [CHANNELS];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // Stage A: L.N terms.
            dpx_next[l] = norm_reg[NORM_STAGES-1][LANE_LIGHT_ONE+l].ux
                        * norm_reg[NORM_STAGES-1][LANE_NORMAL].ux;
            dpy_next[l] = norm_reg[NORM_STAGES-1][LANE_LIGHT_ONE+l].uy
                        * norm_reg[NORM_STAGES-1][LANE_NORMAL].uy;
            // Stage B: exact Q.28 dot.
            d_next[l] = dpx_reg[l] + dpy_reg[l];
            // Stage C: Lambert term and d*n.
            diffc_next[l] = clamp_dot(DOT_W'(d_reg[l]));
            tx_next[l]    = d_reg[l] * nbx_reg;
            ty_next[l]    = d_reg[l] * nby_reg;
            // Stage D: R = round(2 d n) - L, in Q.14.
            shx[l]        = (50'(tx_reg[l]) <<< 1) + HALF_Q28;
            shy[l]        = (50'(ty_reg[l]) <<< 1) + HALF_Q28;
            px_next[l]    = 20'(shx[l] >>> 28) - 20'(cur_lx_reg[l]);
            py_next[l]    = 20'(shy[l] >>> 28) - 20'(cur_ly_reg[l]);
            diffd_next[l] = diffc_reg[l];
            // Stage E: R.V terms.
            ex_next[l]    = px_reg[l] * cur_vx_reg;
            ey_next[l]    = py_reg[l] * cur_vy_reg;
            diffe_next[l] = diffd_reg[l];
            // Stage F: R.V sum.
            sd_next[l]    = 37'(ex_reg[l]) + 37'(ey_reg[l]);
            difff_next[l] = diffe_reg[l];
            // Stage G: clamped specular base; no viewer means no highlight.
            sq_next[0][l] = cur_vok_reg ? clamp_dot(DOT_W'(sd_reg[l])) : '0;
            dq_next[0][l] = difff_reg[l];
            sqp[0][l]     = '0;
            // Squaring stages raise the base to 2^P.
            for (int i = 1; i <= P; i++) begin
                sqp[i][l]     = sq_reg[i-1][l] * sq_reg[i-1][l];
                sqp[i][l]     = sqp[i][l] + 29'd8192;
                sq_next[i][l] = Q_W'(sqp[i][l] >> FRAC_BITS);
                dq_next[i][l] = dq_reg[i-1][l];
            end
            term[l] = (nokq_reg[P] && cur_lok_reg[l])
                    ? (17'(dq_reg[P][l]) + 17'(sq_reg[P][l])) : '0;
        end
        nax_next     = norm_reg[NORM_STAGES-1][LANE_NORMAL].ux;
        nay_next     = norm_reg[NORM_STAGES-1][LANE_NORMAL].uy;
        nbx_next     = nax_reg;
        nby_next     = nay_reg;
        nokq_next[0] = nokf_reg;
        for (int i = 1; i <= P; i++) begin
            nokq_next[i] = nokq_reg[i-1];
        end
        tsum_next = term[0] + term[1];
        for (int c = 0; c < CHANNELS; c++) begin
            // Red sits in the top gain field.
            prod_next[c] = tsum_reg * gains_reg[GAIN_W*(CHANNELS-1-c) +: GAIN_W];
            acc[c]       = 35'(prod_reg[c]) + 35'({amb_reg, {FRAC_BITS{1'b0}}})
                         + 35'd32768;
            out_next[c]  = (acc[c][34:16] > 19'd65535) ? 16'hFFFF : acc[c][31:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dpx_reg   <= dpx_next;
            dpy_reg   <= dpy_next;
            d_reg     <= d_next;
            diffc_reg <= diffc_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            diffd_reg <= diffd_next;
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            diffe_reg <= diffe_next;
            sd_reg    <= sd_next;
            difff_reg <= difff_next;
            sq_reg    <= sq_next;
            dq_reg    <= dq_next;
            nax_reg   <= nax_next;
            nay_reg   <= nay_next;
            nbx_reg   <= nbx_next;
            nby_reg   <= nby_next;
            noka_reg  <= norm_reg[NORM_STAGES-1][LANE_NORMAL].ok;
            nokb_reg  <= noka_reg;
            nokc_reg  <= nokb_reg;
            nokd_reg  <= nokc_reg;
            noke_reg  <= nokd_reg;
            nokf_reg  <= noke_reg;
            nokq_reg  <= nokq_next;
            tsum_reg  <= tsum_next;
            prod_reg  <= prod_next;
            out_reg   <= out_next;
        end
    end

    assign m_axis_tdata = {out_reg[2], out_reg[1], out_reg[0]};

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `TLPS_ASSERT(a_ready_tracks_output,
        s_axis_tready == (!m_axis_tvalid || m_axis_tready),
        "input ready does not follow the output register")
    `TLPS_ASSERT(a_accept_enters_pipe,
        s_axis_tvalid && s_axis_tready |=> valid_reg[0],
        "accepted beat did not enter the first stage")
    `TLPS_ASSERT(a_stall_freezes_pipe,
        !s_axis_tready |=> $stable(valid_reg),
        "pipeline moved during an output stall")
    `TLPS_ASSERT_NEVER(a_diffuse_bounded,
        valid_reg[ST_C] && (diffc_reg[0] > Q_W'(UNIT_ONE) || diffc_reg[1] > Q_W'(UNIT_ONE)),
        "Lambert term above one")

endmodule
